// ===== src/sdf_pkg.sv =====
package sdf_pkg;

  // Sizing of the conversion datapath.
  localparam int VALUE_W     = 64;  // width of the value port
  localparam int VALUE_BITS  = 64;  // low bits of the value taken as two's complement
  localparam int DIGIT_SLOTS = 20;  // decimal digits kept
  localparam int MAX_TEXT    = 64;  // characters emitted at most per transaction

  // Field widths of a transaction.
  localparam int FW_W   = 7;
  localparam int PREC_W = 6;
  localparam int CHAR_W = 8;
  // Text positions: sign + 63 precision zeros + digits, or a 7-bit width, fit in 7 bits.
  localparam int TEXT_W = 7;

  // The binary to BCD converter takes this many magnitude bits per cycle.
  localparam int STEP_BITS    = 2;
  localparam int DABBLE_STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_BITS     = DABBLE_STEPS * STEP_BITS;
  localparam int DABBLE_CNT_W = $clog2(DABBLE_STEPS);
  localparam int DIG_IDX_W    = $clog2(DIGIT_SLOTS);
  localparam int DIG_CNT_W    = $clog2(DIGIT_SLOTS + 1);

  // Job queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // A classified transaction as it waits in the queue.
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [FW_W-1:0]       field_width;
    logic                  has_prec;
    logic [PREC_W-1:0]     prec;
    logic                  left;
    logic                  zero;
    logic                  sign_len;
    logic [CHAR_W-1:0]     sign_ch;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/sdf_front.sv =====
module sdf_front (
  input  logic [sdf_pkg::VALUE_W-1:0] value_i,
  input  logic [sdf_pkg::FW_W-1:0]    field_width_i,
  input  logic                        has_precision_i,
  input  logic [sdf_pkg::PREC_W-1:0]  precision_i,
  input  logic                        left_justify_i,
  input  logic                        force_plus_i,
  input  logic                        space_sign_i,
  input  logic                        zero_pad_i,
  input  logic                        start_i,
  input  sdf_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output sdf_pkg::job_t               job_o
);

  logic [sdf_pkg::VALUE_BITS-1:0] raw;
  logic                           neg;

  assign raw    = value_i[sdf_pkg::VALUE_BITS-1:0];
  assign neg    = raw[sdf_pkg::VALUE_BITS-1];
  assign push_o = start_i && !q_status_i.full;

  // The negation of the most negative value wraps to itself, which is its
  // correct magnitude when read unsigned.
  always_comb begin
    job_o.mag         = neg ? (~raw + 1'b1) : raw;
    job_o.field_width = field_width_i;
    job_o.has_prec    = has_precision_i;
    job_o.prec        = precision_i;
    job_o.left        = left_justify_i;
    job_o.zero        = zero_pad_i && !has_precision_i && !left_justify_i;
    job_o.sign_len    = neg || force_plus_i || space_sign_i;
    if (neg) begin
      job_o.sign_ch = sdf_pkg::CH_MINUS;
    end else if (force_plus_i) begin
      job_o.sign_ch = sdf_pkg::CH_PLUS;
    end else begin
      job_o.sign_ch = sdf_pkg::CH_SPACE;
    end
  end

endmodule

// ===== src/sdf_queue.sv =====
module sdf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sdf_pkg::job_t      job_i,
  input  logic               pop_i,
  output sdf_pkg::job_t      job_o,
  output sdf_pkg::q_status_t status_o
);

  sdf_pkg::job_t                entry_q [sdf_pkg::QUEUE_DEPTH];
  logic [sdf_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sdf_pkg::QCNT_W-1:0]   cnt_q;
  logic                         do_push, do_pop;

  assign status_o.full  = (cnt_q == sdf_pkg::QCNT_W'(sdf_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/sdf_back.sv =====
module sdf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdf_pkg::job_t              job_i,
  input  sdf_pkg::q_status_t         q_status_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic [sdf_pkg::CHAR_W-1:0] out_char_o,
  output logic                       last_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DABBLE,
    B_PLAN,
    B_EMIT
  } state_e;

  localparam int TW = sdf_pkg::TEXT_W;

  state_e                            state_q;
  logic [sdf_pkg::DABBLE_CNT_W-1:0]  step_q;
  logic [sdf_pkg::MAG_BITS-1:0]      mag_q;
  logic [3:0]                        digit_q [sdf_pkg::DIGIT_SLOTS];
  logic [3:0]                        digit_d [sdf_pkg::DIGIT_SLOTS];
  logic [3:0]                        adj     [sdf_pkg::DIGIT_SLOTS];
  logic [sdf_pkg::DIG_CNT_W-1:0]     ndig_q, ndig_d;

  // Options of the transaction in progress.
  logic [sdf_pkg::FW_W-1:0]          fw_q;
  logic                              has_prec_q;
  logic [sdf_pkg::PREC_W-1:0]        prec_q;
  logic                              left_q, zero_q, sign_len_q;
  logic [sdf_pkg::CHAR_W-1:0]        sign_ch_q;

  // Layout of the text: segment ends and character count.
  logic [TW-1:0] s1_q, s2_q, s3_q, s4_q, count_q, pos_q;
  logic [TW-1:0] nlen, prec_t, prec_zeros, slen, fw_t, total, pad, lead, zeros;
  logic [TW-1:0] s1, s2, s3, s4, count, didx;
  logic [3:0]    dsel;

  assign pop_o = (state_q == B_IDLE) && !q_status_i.empty;

  // Shift-and-add-3 conversion, STEP_BITS magnitude bits per cycle. The digit
  // count grows by at most one per bit and saturates at the slot count.
  always_comb begin
    digit_d = digit_q;
    ndig_d  = ndig_q;
    adj     = digit_q;
    for (int j = 0; j < sdf_pkg::STEP_BITS; j++) begin
      for (int i = 0; i < sdf_pkg::DIGIT_SLOTS; i++) begin
        adj[i] = (digit_d[i] >= 4'd5) ? digit_d[i] + 4'd3 : digit_d[i];
      end
      digit_d[0] = {adj[0][2:0], mag_q[sdf_pkg::MAG_BITS-1-j]};
      for (int i = 1; i < sdf_pkg::DIGIT_SLOTS; i++) begin
        digit_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
      if (ndig_d < sdf_pkg::DIG_CNT_W'(sdf_pkg::DIGIT_SLOTS) &&
          digit_d[ndig_d[sdf_pkg::DIG_IDX_W-1:0]] != 4'd0) begin
        ndig_d = ndig_d + 1'b1;
      end
    end
  end

  always_comb begin
    if (ndig_q == '0 && !(has_prec_q && prec_q == '0)) begin
      nlen = TW'(1);
    end else begin
      nlen = TW'(ndig_q);
    end
    prec_t     = TW'(prec_q);
    prec_zeros = (has_prec_q && prec_t > nlen) ? prec_t - nlen : '0;
    slen       = TW'(sign_len_q) + prec_zeros + nlen;
    fw_t       = TW'(fw_q);
    total      = (fw_t > slen) ? fw_t : slen;
    pad        = total - slen;
    lead       = (!left_q && !zero_q) ? pad : '0;
    zeros      = prec_zeros + (zero_q ? pad : '0);
    s1         = lead;
    s2         = s1 + TW'(sign_len_q);
    s3         = s2 + zeros;
    s4         = s3 + nlen;
    count      = (total > TW'(sdf_pkg::MAX_TEXT)) ? TW'(sdf_pkg::MAX_TEXT) : total;
  end

  // Digits are stored least significant first.
  assign didx = s4_q - pos_q - 1'b1;
  assign dsel = digit_q[didx[sdf_pkg::DIG_IDX_W-1:0]];

  always_comb begin
    if (pos_q < s1_q) begin
      out_char_o = sdf_pkg::CH_SPACE;
    end else if (pos_q < s2_q) begin
      out_char_o = sign_ch_q;
    end else if (pos_q < s3_q) begin
      out_char_o = sdf_pkg::CH_ZERO;
    end else if (pos_q < s4_q) begin
      out_char_o = sdf_pkg::CH_ZERO + {4'd0, dsel};
    end else begin
      out_char_o = sdf_pkg::CH_SPACE;
    end
  end

  assign strobe_o = (state_q == B_EMIT);
  assign last_o   = strobe_o && (pos_q + 1'b1 == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
      ndig_q  <= '0;
      pos_q   <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            mag_q      <= sdf_pkg::MAG_BITS'(job_i.mag);
            fw_q       <= job_i.field_width;
            has_prec_q <= job_i.has_prec;
            prec_q     <= job_i.prec;
            left_q     <= job_i.left;
            zero_q     <= job_i.zero;
            sign_len_q <= job_i.sign_len;
            sign_ch_q  <= job_i.sign_ch;
            for (int i = 0; i < sdf_pkg::DIGIT_SLOTS; i++) begin
              digit_q[i] <= 4'd0;
            end
            ndig_q  <= '0;
            step_q  <= sdf_pkg::DABBLE_CNT_W'(sdf_pkg::DABBLE_STEPS - 1);
            state_q <= B_DABBLE;
          end
        end
        B_DABBLE: begin
          digit_q <= digit_d;
          ndig_q  <= ndig_d;
          mag_q   <= mag_q << sdf_pkg::STEP_BITS;
          if (step_q == '0) begin
            state_q <= B_PLAN;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        B_PLAN: begin
          s1_q    <= s1;
          s2_q    <= s2;
          s3_q    <= s3;
          s4_q    <= s4;
          count_q <= count;
          ndig_q  <= sdf_pkg::DIG_CNT_W'(nlen);
          pos_q   <= '0;
          state_q <= (count == '0) ? B_IDLE : B_EMIT;
        end
        B_EMIT: begin
          pos_q <= pos_q + 1'b1;
          if (last_o) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/signed_decimal_formatter.sv =====
// Signed decimal formatter: turns one signed integer and its conversion
// options (field width, optional precision, left-justify, plus, space and
// zero flags) into printf-style decimal text, one ASCII character per cycle.
//
// Input channel: a transaction is taken at a rising edge where start_i is
// high and busy_o is low. busy_o is high only while the two-entry job queue
// is full, so up to two transactions may wait behind the one being formatted.
// Output channel: each character is on out_char_o for exactly one cycle
// while strobe_o is high; last_o marks the final character of a transaction.
// The receiver cannot stall, so characters of one transaction come out on
// consecutive cycles. A transaction whose text is empty (zero with a
// precision of zero, no sign flag and no width) produces no strobe at all.
//
// The back end takes a job from the queue, runs the binary to BCD converter
// (two magnitude bits per cycle), lays out the text, and then emits its
// characters (0 to 64). It takes the next job only once it is back in idle
// after the final character. Reset empties the queue and returns the back
// end to idle.
module signed_decimal_formatter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [sdf_pkg::VALUE_W-1:0] value_i,
  input  logic [sdf_pkg::FW_W-1:0]    field_width_i,
  input  logic                        has_precision_i,
  input  logic [sdf_pkg::PREC_W-1:0]  precision_i,
  input  logic                        left_justify_i,
  input  logic                        force_plus_i,
  input  logic                        space_sign_i,
  input  logic                        zero_pad_i,
  output logic                        strobe_o,
  output logic [sdf_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        last_o
);

  sdf_pkg::job_t      push_job, head_job;
  sdf_pkg::q_status_t q_status;
  logic               push, pop;

  // The front end classifies the value (sign, magnitude, effective flags)
  // in the cycle it is accepted, and the queue stores the result.
  sdf_front u_front (
    .value_i         (value_i),
    .field_width_i   (field_width_i),
    .has_precision_i (has_precision_i),
    .precision_i     (precision_i),
    .left_justify_i  (left_justify_i),
    .force_plus_i    (force_plus_i),
    .space_sign_i    (space_sign_i),
    .zero_pad_i      (zero_pad_i),
    .start_i         (start_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .job_o           (push_job)
  );

  sdf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // The back end converts the magnitude to decimal digits and then walks
  // the text: lead spaces, sign, zeros, digits, trailing spaces.
  sdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  assign busy_o = q_status.full;

  // The characters of one transaction leave without gaps.
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a transaction's text");

  // After the final character the back end returns to idle, so the cycle after it carries no strobe.
  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("character emitted right after last");

  // The back end takes a job only when the queue holds one and it is not emitting.
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty && !strobe_o)
    else $error("job taken from an empty queue or while emitting");

endmodule
